[src/ust_pkg.sv]
`timescale 1ns / 1ps

package ust_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int OCNT_W   = 6;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DUP    = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  typedef struct packed {
    logic [1:0]        status;
    logic [OCNT_W-1:0] count;
  } result_t;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic [IDX_W-1:0]  rd_addr;
  } ram_req_t;

  // Count as carried on the result: modulo 64.
  function automatic logic [OCNT_W-1:0] out_count(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+OCNT_W-1:0] ext;
    ext = {{OCNT_W{1'b0}}, cnt};
    return ext[OCNT_W-1:0];
  endfunction

endpackage

[src/ust_ram.sv]
`timescale 1ns / 1ps

module ust_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[src/ust_ctrl.sv]
`timescale 1ns / 1ps

module ust_ctrl
  import ust_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_cmd,
  input  logic [VAL_W-1:0] in_value,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res,
  output ram_req_t         ram_req,
  input  logic [VAL_W-1:0] rd_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             found_r, found_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [IDX_W-1:0] last_idx;
  logic [CNT_W-1:0] count_m1;

  assign count_m1 = count_r - CNT_W'(1);
  assign last_idx = count_m1[IDX_W-1:0];

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    value_nxt  = value_r;
    idx_nxt    = idx_r;
    slot_nxt   = slot_r;
    found_nxt  = found_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    ram_req    = '{wr_en: 1'b0, wr_addr: slot_r, wr_data: rd_data, rd_addr: idx_r};

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        ram_req.rd_addr = '0;
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          value_nxt = in_value;
          if (in_cmd == CMD_CLEAR) begin
            count_nxt  = '0;
            status_nxt = ST_OK;
            state_nxt  = S_FIN;
          end else if (count_r == '0) begin
            found_nxt = 1'b0;
            state_nxt = S_DECIDE;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // rd_data holds the entry at idx_r
        if (rd_data == value_r) begin
          found_nxt = 1'b1;
          slot_nxt  = idx_r;
          state_nxt = S_DECIDE;
        end else if (idx_r == last_idx) begin
          found_nxt = 1'b0;
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt         = idx_r + IDX_W'(1);
          ram_req.rd_addr = idx_r + IDX_W'(1);
        end
      end
      S_DECIDE: begin
        state_nxt = S_FIN;
        unique case (cmd_r)
          CMD_INSERT: begin
            if (found_r) begin
              status_nxt = ST_DUP;
            end else if (count_r >= CNT_W'(CAPACITY)) begin
              status_nxt = ST_FULL;
            end else begin
              ram_req.wr_en   = 1'b1;
              ram_req.wr_addr = count_r[IDX_W-1:0];
              ram_req.wr_data = value_r;
              count_nxt       = count_r + CNT_W'(1);
              status_nxt      = ST_OK;
            end
          end
          CMD_REMOVE: begin
            if (found_r) begin
              ram_req.rd_addr = last_idx;
              state_nxt       = S_MOVE;
            end else begin
              status_nxt = ST_ABSENT;
            end
          end
          CMD_QUERY: begin
            status_nxt = found_r ? ST_OK : ST_ABSENT;
          end
          CMD_CLEAR: begin
            status_nxt = ST_OK;
          end
        endcase
      end
      S_MOVE: begin
        // last entry overwrites the removed one
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = slot_r;
        ram_req.wr_data = rd_data;
        count_nxt       = count_m1;
        status_nxt      = ST_OK;
        state_nxt       = S_FIN;
      end
      S_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.status = status_r;
  assign res.count  = out_count(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    cmd_r    <= cmd_nxt;
    value_r  <= value_nxt;
    idx_r    <= idx_nxt;
    slot_r   <= slot_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
  end

endmodule

[src/unordered_set_table_top.sv]
`timescale 1ns / 1ps
// Channel  Ports                      Payload
// in       in_tvalid/in_tready        tuser: cmd[1:0]; tdata: value[31:0]
// out      out_tvalid/out_tready      tdata: status[1:0], count[7:2]
//
// A clear passes S_IDLE and S_FIN; any other request passes S_IDLE, S_SCAN
// (skipped on an empty set; one entry per cycle via the single RAM read port, at
// most the fill count), S_DECIDE and S_FIN; a remove that hits passes S_MOVE to
// fetch and move the last entry. Synchronous active-low reset empties the set.
// The output register lets the next request be taken while a result waits;
// a second finished result holds until the first transfer completes.

module unordered_set_table_top
  import ust_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // status[1:0], count[7:2]
);

  result_t          res;
  logic             res_valid;
  logic             res_ready;
  ram_req_t         ram_req;
  logic [VAL_W-1:0] rd_data;

  logic             out_valid_r;
  result_t          out_res_r;

  ust_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_value  (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_req   (ram_req),
    .rd_data   (rd_data)
  );

  ust_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_addr (ram_req.rd_addr),
    .rd_data (rd_data)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.count, out_res_r.status};

endmodule
